// ===== hw/rtl/word_cpu_instruction_step_top_macros.svh =====
// Assertion macros for the instruction step core.
// Used by word_cpu_instruction_step_top; expects clk_i and rst_ni in scope.
`ifndef WORD_CPU_INSTRUCTION_STEP_TOP_MACROS_SVH
`define WORD_CPU_INSTRUCTION_STEP_TOP_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while in reset.
`define WCIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define WCIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wcis_pkg.sv =====
// Shared types, codes and helpers of the instruction step core.
// No dependencies; imported by wcis_div and word_cpu_instruction_step_top.
package wcis_pkg;

  typedef enum logic [2:0] {
    LOC_REG,
    LOC_MEM,
    LOC_SP,
    LOC_PC,
    LOC_O,
    LOC_LIT
  } loc_e;

  typedef struct packed {
    loc_e        kind;
    logic [15:0] val;
  } loc_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

  localparam logic [3:0] OP_NONBASIC = 4'h0;
  localparam logic [3:0] OP_SET = 4'h1;
  localparam logic [3:0] OP_ADD = 4'h2;
  localparam logic [3:0] OP_SUB = 4'h3;
  localparam logic [3:0] OP_MUL = 4'h4;
  localparam logic [3:0] OP_DIV = 4'h5;
  localparam logic [3:0] OP_MOD = 4'h6;
  localparam logic [3:0] OP_SHL = 4'h7;
  localparam logic [3:0] OP_SHR = 4'h8;
  localparam logic [3:0] OP_AND = 4'h9;
  localparam logic [3:0] OP_BOR = 4'hA;
  localparam logic [3:0] OP_XOR = 4'hB;
  localparam logic [3:0] OP_IFE = 4'hC;
  localparam logic [3:0] OP_IFN = 4'hD;
  localparam logic [3:0] OP_IFG = 4'hE;
  localparam logic [3:0] OP_IFB = 4'hF;

  localparam logic [5:0] NB_JSR = 6'h01;

  localparam logic [5:0] CODE_POP = 6'h18;
  localparam logic [5:0] CODE_PEEK = 6'h19;
  localparam logic [5:0] CODE_PUSH = 6'h1A;
  localparam logic [5:0] CODE_SP = 6'h1B;
  localparam logic [5:0] CODE_PC = 6'h1C;
  localparam logic [5:0] CODE_O = 6'h1D;
  localparam logic [5:0] CODE_NW_IND = 6'h1E;
  localparam logic [5:0] CODE_NW_LIT = 6'h1F;

  // True when an operand code consumes a next word.
  function automatic logic extra_word(input logic [5:0] code);
    return (code[5:3] == 3'b010) || (code == CODE_NW_IND) || (code == CODE_NW_LIT);
  endfunction

endpackage

// ===== hw/rtl/wcis_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on wcis_pkg for the response struct.
module wcis_div
  import wcis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output div_rsp_t    rsp_o
);

  logic        run_q;
  logic [4:0]  cnt_q;
  logic        done_q;
  logic [31:0] dvd_q;
  logic [15:0] rem_q;
  logic [15:0] dsr_q;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q, dvd_q[31]};
  assign fits = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[30:0], fits};
      rem_q <= fits ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem = rem_q;

endmodule

// ===== hw/rtl/word_cpu_instruction_step_top.sv =====
// Top level of the 16-bit word CPU instruction step core.
// Depends on wcis_pkg, wcis_div and word_cpu_instruction_step_top_macros.svh.
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+--------------------------------------
// command   | start, busy (start&!busy) | kind_i, address_i, data_i
// result    | valid_o (one-cycle pulse) | pc_o sp_o overflow_o reg_*_o next_word_o
//
// After reset the word memory is cleared one word a cycle; busy stays high
// during that pass. A load writes its word, then passes FIN and DONE. An
// instruction goes FETCH, DECODE, OPD per operand (OPD_NW per next word), RDB,
// RDA, EXEC, FIN and DONE; a failed test adds SKIP and SKIP2. JSR reads only b
// and has JSR in place of EXEC; a reserved non-basic word goes DECODE to FIN. DIV
// and MOD with a nonzero divisor wait in DIVW for the bit-serial divider.
// The receiver cannot stall: each result is shown for exactly one cycle.
module word_cpu_instruction_step_top
  import wcis_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  output logic        valid_o,
  output logic [15:0] pc_o,
  output logic [15:0] sp_o,
  output logic [15:0] overflow_o,
  output logic [15:0] reg_a_o,
  output logic [15:0] reg_b_o,
  output logic [15:0] reg_c_o,
  output logic [15:0] reg_x_o,
  output logic [15:0] reg_y_o,
  output logic [15:0] reg_z_o,
  output logic [15:0] reg_i_o,
  output logic [15:0] reg_j_o,
  output logic [15:0] next_word_o
);

`include "word_cpu_instruction_step_top_macros.svh"

  localparam int MemWords = 1 << ADDR_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_OPD,
    ST_OPD_NW,
    ST_RDB,
    ST_RDA,
    ST_EXEC,
    ST_DIVW,
    ST_JSR,
    ST_SKIP,
    ST_SKIP2,
    ST_FIN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [ADDR_BITS-1:0]   clr_cnt_q;
  logic [15:0]            regs_q [8];
  logic [15:0]            pc_q, sp_q, o_q;
  logic [15:0]            ir_q;
  logic                   cur_b_q;
  logic                   is_jsr_q;
  loc_t                   la_q, lb_q;
  logic [15:0]            bval_q;

  // Word memory: one write port, one registered read port.
  logic [15:0]            mem_q [MemWords];
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  logic [15:0]            mem_wdata;
  logic [15:0]            rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Operand code under decode and its register read.
  logic [5:0]  code;
  logic        code_nw;
  loc_t        cur_loc;
  logic [2:0]  rf_idx;
  logic [15:0] rf_rd;
  logic [15:0] loc_val;
  logic [15:0] sp_dec;

  assign code = cur_b_q ? ir_q[15:10] : ir_q[9:4];
  assign code_nw = extra_word(code);
  assign cur_loc = (state_q == ST_RDA) ? lb_q : la_q;
  assign rf_idx = (state_q == ST_OPD || state_q == ST_OPD_NW) ? code[2:0] : cur_loc.val[2:0];
  assign rf_rd = regs_q[rf_idx];
  assign sp_dec = sp_q - 16'd1;

  always_comb begin
    unique case (cur_loc.kind)
      LOC_REG: loc_val = rf_rd;
      LOC_MEM: loc_val = rdata_q;
      LOC_SP:  loc_val = sp_q;
      LOC_PC:  loc_val = pc_q;
      LOC_O:   loc_val = o_q;
      default: loc_val = cur_loc.val;
    endcase
  end

  // Shared arithmetic unit: one operation on a and b per instruction.
  logic [3:0]  op;
  logic [15:0] aval;
  logic [16:0] sum;
  logic [31:0] prod;
  logic [47:0] shl_w;
  logic [31:0] shr_w;
  logic        need_div;
  logic        skip_cond;
  logic        wb_en, ovf_en;
  logic [15:0] wb_val, ovf_val;
  logic        div_start;
  div_rsp_t    div_rsp;
  logic        div_fin;

  assign op = ir_q[3:0];
  assign aval = loc_val;
  assign sum = {1'b0, aval} + {1'b0, bval_q};
  assign prod = aval * bval_q;
  assign shl_w = {32'b0, aval} << bval_q[5:0];
  assign shr_w = {aval, 16'b0} >> bval_q[4:0];
  assign need_div = (op == OP_DIV || op == OP_MOD) && (bval_q != 16'd0);
  assign div_start = (state_q == ST_EXEC) && need_div;
  assign div_fin = (state_q == ST_DIVW) && div_rsp.done;

  wcis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((op == OP_DIV) ? {aval, 16'b0} : {16'b0, aval}),
    .divisor_i  (bval_q),
    .rsp_o      (div_rsp)
  );

  always_comb begin
    wb_en = 1'b0;
    wb_val = '0;
    ovf_en = 1'b0;
    ovf_val = '0;
    skip_cond = 1'b0;
    if (div_fin) begin
      wb_en = 1'b1;
      if (op == OP_DIV) begin
        wb_val = div_rsp.quot[31:16];
        ovf_en = 1'b1;
        ovf_val = div_rsp.quot[15:0];
      end else begin
        wb_val = div_rsp.rem;
      end
    end else if (state_q == ST_EXEC && !need_div) begin
      unique case (op)
        OP_SET: begin wb_en = 1'b1; wb_val = bval_q; end
        OP_ADD: begin
          wb_en = 1'b1; wb_val = sum[15:0];
          ovf_en = 1'b1; ovf_val = {15'b0, sum[16]};
        end
        OP_SUB: begin
          wb_en = 1'b1; wb_val = 16'(aval - bval_q);
          ovf_en = 1'b1; ovf_val = (aval < bval_q) ? 16'hFFFF : 16'h0000;
        end
        OP_MUL: begin
          wb_en = 1'b1; wb_val = prod[15:0];
          ovf_en = 1'b1; ovf_val = prod[31:16];
        end
        // Division by zero lands here: result and O are zero.
        OP_DIV: begin wb_en = 1'b1; ovf_en = 1'b1; end
        OP_MOD: wb_en = 1'b1;
        OP_SHL: begin
          wb_en = 1'b1; ovf_en = 1'b1;
          if (bval_q < 16'd48) begin
            wb_val = shl_w[15:0];
            ovf_val = shl_w[31:16];
          end
        end
        OP_SHR: begin
          wb_en = 1'b1; ovf_en = 1'b1;
          if (bval_q < 16'd16) wb_val = aval >> bval_q[3:0];
          if (bval_q < 16'd32) ovf_val = shr_w[15:0];
        end
        OP_AND: begin wb_en = 1'b1; wb_val = aval & bval_q; end
        OP_BOR: begin wb_en = 1'b1; wb_val = aval | bval_q; end
        OP_XOR: begin wb_en = 1'b1; wb_val = aval ^ bval_q; end
        OP_IFE: skip_cond = aval != bval_q;
        OP_IFN: skip_cond = aval == bval_q;
        OP_IFG: skip_cond = !(aval > bval_q);
        OP_IFB: skip_cond = (aval & bval_q) == 16'd0;
        default: ;
      endcase
    end
  end

  // Memory port selection per state.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = pc_q[ADDR_BITS-1:0];
    mem_wdata = '0;
    mem_raddr = pc_q[ADDR_BITS-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt_q;
      end
      ST_IDLE: begin
        mem_we = start && !kind_i;
        mem_waddr = address_i[ADDR_BITS-1:0];
        mem_wdata = data_i;
      end
      ST_RDB: mem_raddr = lb_q.val[ADDR_BITS-1:0];
      ST_RDA: mem_raddr = la_q.val[ADDR_BITS-1:0];
      ST_EXEC, ST_DIVW: begin
        mem_we = wb_en && (la_q.kind == LOC_MEM);
        mem_waddr = la_q.val[ADDR_BITS-1:0];
        mem_wdata = wb_val;
      end
      ST_JSR: begin
        mem_we = 1'b1;
        mem_waddr = sp_dec[ADDR_BITS-1:0];
        mem_wdata = pc_q;
      end
      default: ;
    endcase
  end

  // Decode of the current operand code into a location.
  loc_t opd_loc;
  always_comb begin
    opd_loc.kind = LOC_LIT;
    opd_loc.val = {11'b0, code[4:0]};
    if (state_q == ST_OPD_NW) begin
      if (code == CODE_NW_LIT) begin
        opd_loc.val = rdata_q;
      end else if (code == CODE_NW_IND) begin
        opd_loc.kind = LOC_MEM;
        opd_loc.val = rdata_q;
      end else begin
        opd_loc.kind = LOC_MEM;
        opd_loc.val = 16'(rdata_q + rf_rd);
      end
    end else begin
      priority if (code[5:3] == 3'b000) begin
        opd_loc.kind = LOC_REG;
        opd_loc.val = {13'b0, code[2:0]};
      end else if (code[5:3] == 3'b001) begin
        opd_loc.kind = LOC_MEM;
        opd_loc.val = rf_rd;
      end else if (code == CODE_POP || code == CODE_PEEK) begin
        opd_loc.kind = LOC_MEM;
        opd_loc.val = sp_q;
      end else if (code == CODE_PUSH) begin
        opd_loc.kind = LOC_MEM;
        opd_loc.val = sp_dec;
      end else if (code == CODE_SP) begin
        opd_loc.kind = LOC_SP;
      end else if (code == CODE_PC) begin
        opd_loc.kind = LOC_PC;
      end else if (code == CODE_O) begin
        opd_loc.kind = LOC_O;
      end else begin
        opd_loc.kind = LOC_LIT;
      end
    end
  end

  logic [15:0] skip_n;
  assign skip_n = (rdata_q[3:0] != OP_NONBASIC)
    ? 16'(extra_word(rdata_q[9:4])) + 16'(extra_word(rdata_q[15:10]))
    : 16'(extra_word(rdata_q[15:10]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_cnt_q <= '0;
      pc_q <= '0;
      sp_q <= '0;
      o_q <= '0;
      cur_b_q <= 1'b0;
      is_jsr_q <= 1'b0;
      for (int k = 0; k < 8; k++) regs_q[k] <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == {ADDR_BITS{1'b1}}) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) state_q <= kind_i ? ST_FETCH : ST_FIN;
        end
        ST_FETCH: begin
          pc_q <= pc_q + 16'd1;
          state_q <= ST_DECODE;
        end
        ST_DECODE: begin
          ir_q <= rdata_q;
          if (rdata_q[3:0] == OP_NONBASIC) begin
            is_jsr_q <= 1'b1;
            cur_b_q <= 1'b1;
            state_q <= (rdata_q[9:4] == NB_JSR) ? ST_OPD : ST_FIN;
          end else begin
            is_jsr_q <= 1'b0;
            cur_b_q <= 1'b0;
            state_q <= ST_OPD;
          end
        end
        ST_OPD, ST_OPD_NW: begin
          if (state_q == ST_OPD && code_nw) begin
            pc_q <= pc_q + 16'd1;
            state_q <= ST_OPD_NW;
          end else begin
            if (state_q == ST_OPD && code == CODE_POP) sp_q <= sp_q + 16'd1;
            if (state_q == ST_OPD && code == CODE_PUSH) sp_q <= sp_dec;
            if (cur_b_q) begin
              lb_q <= opd_loc;
              state_q <= ST_RDB;
            end else begin
              la_q <= opd_loc;
              cur_b_q <= 1'b1;
              state_q <= ST_OPD;
            end
          end
        end
        ST_RDB: state_q <= ST_RDA;
        ST_RDA: begin
          bval_q <= loc_val;
          state_q <= is_jsr_q ? ST_JSR : ST_EXEC;
        end
        ST_EXEC, ST_DIVW: begin
          // O from the operation wins over O as destination.
          if (wb_en) begin
            unique case (la_q.kind)
              LOC_REG: regs_q[la_q.val[2:0]] <= wb_val;
              LOC_SP:  sp_q <= wb_val;
              LOC_PC:  pc_q <= wb_val;
              LOC_O:   if (!ovf_en) o_q <= wb_val;
              default: ;
            endcase
          end
          if (ovf_en) o_q <= ovf_val;
          if (state_q == ST_EXEC) begin
            priority if (need_div) state_q <= ST_DIVW;
            else if (skip_cond) state_q <= ST_SKIP;
            else state_q <= ST_FIN;
          end else if (div_rsp.done) begin
            state_q <= ST_FIN;
          end
        end
        ST_JSR: begin
          sp_q <= sp_dec;
          pc_q <= bval_q;
          state_q <= ST_FIN;
        end
        ST_SKIP: begin
          pc_q <= pc_q + 16'd1;
          state_q <= ST_SKIP2;
        end
        ST_SKIP2: begin
          pc_q <= pc_q + skip_n;
          state_q <= ST_FIN;
        end
        ST_FIN: state_q <= ST_DONE;
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The result is presented from the architectural registers; the word at
  // the new PC arrives from the read issued in the cycle before.
  assign busy = state_q != ST_IDLE;
  assign valid_o = state_q == ST_DONE;
  assign pc_o = pc_q;
  assign sp_o = sp_q;
  assign overflow_o = o_q;
  assign reg_a_o = regs_q[0];
  assign reg_b_o = regs_q[1];
  assign reg_c_o = regs_q[2];
  assign reg_x_o = regs_q[3];
  assign reg_y_o = regs_q[4];
  assign reg_z_o = regs_q[5];
  assign reg_i_o = regs_q[6];
  assign reg_j_o = regs_q[7];
  assign next_word_o = rdata_q;

  `WCIS_ASSERT(a_valid_busy, !valid_o || busy, "result strobe outside a busy step")
  `WCIS_ASSERT_NEXT(a_valid_pulse, valid_o, !valid_o, "result strobe longer than one cycle")
  `WCIS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
  `WCIS_ASSERT(a_div_state, !div_rsp.done || state_q == ST_DIVW, "divider done outside wait")

endmodule

// ===== tb/word_cpu_instruction_step_top_tb.sv =====
// Self-checking testbench for the word CPU instruction step core.
// Depends on wcis_pkg and word_cpu_instruction_step_top; holds its own CPU predictor.
module word_cpu_instruction_step_top_tb;
  import wcis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung. The limit also
  // has to cover the memory clearing pass after reset.
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned RANDOM_ITEMS = 1525;

  typedef struct {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] ovf;
    logic [15:0] gr[8];
    logic [15:0] nxt;
  } cpu_view_t;

  // The scoreboard models the CPU state and keeps the views still to come.
  class cpu_scoreboard;
    logic [15:0] mem[65536];
    logic [15:0] gr[8];
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] ovf;
    cpu_view_t   pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned executed;

    function new();
      foreach (mem[k]) mem[k] = '0;
      foreach (gr[k]) gr[k] = '0;
      pc = '0;
      sp = '0;
      ovf = '0;
      errors = 0;
      checked = 0;
      executed = 0;
    endfunction

    function logic [15:0] fetch();
      logic [15:0] w;
      w = mem[pc];
      pc = pc + 16'd1;
      return w;
    endfunction

    function bit takes_word(logic [5:0] code);
      return (code >= 6'h10 && code < 6'h18) || code == CODE_NW_IND || code == CODE_NW_LIT;
    endfunction

    function loc_t locate(logic [5:0] code);
      loc_t l;
      l.kind = LOC_LIT;
      l.val = '0;
      if (code < 6'h08) begin
        l.kind = LOC_REG;
        l.val = 16'(code);
      end else if (code < 6'h10) begin
        l.kind = LOC_MEM;
        l.val = gr[code[2:0]];
      end else if (code < 6'h18) begin
        l.kind = LOC_MEM;
        l.val = fetch();
        l.val = l.val + gr[code[2:0]];
      end else if (code == CODE_POP) begin
        l.kind = LOC_MEM;
        l.val = sp;
        sp = sp + 16'd1;
      end else if (code == CODE_PEEK) begin
        l.kind = LOC_MEM;
        l.val = sp;
      end else if (code == CODE_PUSH) begin
        sp = sp - 16'd1;
        l.kind = LOC_MEM;
        l.val = sp;
      end else if (code == CODE_SP) begin
        l.kind = LOC_SP;
      end else if (code == CODE_PC) begin
        l.kind = LOC_PC;
      end else if (code == CODE_O) begin
        l.kind = LOC_O;
      end else if (code == CODE_NW_IND) begin
        l.kind = LOC_MEM;
        l.val = fetch();
      end else if (code == CODE_NW_LIT) begin
        l.val = fetch();
      end else begin
        l.val = 16'(code[4:0]);
      end
      return l;
    endfunction

    function logic [15:0] peek_loc(loc_t l);
      case (l.kind)
        LOC_REG: return gr[l.val[2:0]];
        LOC_MEM: return mem[l.val];
        LOC_SP:  return sp;
        LOC_PC:  return pc;
        LOC_O:   return ovf;
        default: return l.val;
      endcase
    endfunction

    function void poke_loc(loc_t l, logic [15:0] v);
      case (l.kind)
        LOC_REG: gr[l.val[2:0]] = v;
        LOC_MEM: mem[l.val] = v;
        LOC_SP:  sp = v;
        LOC_PC:  pc = v;
        LOC_O:   ovf = v;
        default: ;
      endcase
    endfunction

    // A failed test skips the whole following instruction with its next words.
    function void skip_next();
      logic [15:0] w;
      logic [15:0] n;
      w = fetch();
      n = 16'(takes_word(w[15:10]));
      if (w[3:0] != OP_NONBASIC) n = n + 16'(takes_word(w[9:4]));
      pc = pc + n;
    endfunction

    function void execute();
      logic [15:0] w;
      logic [3:0]  op;
      loc_t        la;
      loc_t        lb;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      logic [63:0] wide;
      logic [15:0] target;
      w = fetch();
      op = w[3:0];
      if (op == OP_NONBASIC) begin
        if (w[9:4] == NB_JSR) begin
          lb = locate(w[15:10]);
          target = peek_loc(lb);
          sp = sp - 16'd1;
          mem[sp] = pc;
          pc = target;
        end
        return;
      end
      la = locate(w[9:4]);
      lb = locate(w[15:10]);
      b = 32'(peek_loc(lb));
      a = 32'(peek_loc(la));
      case (op)
        OP_SET: poke_loc(la, b[15:0]);
        OP_ADD: begin
          r = a + b;
          poke_loc(la, r[15:0]);
          ovf = r[16] ? 16'd1 : 16'd0;
        end
        OP_SUB: begin
          r = a - b;
          poke_loc(la, r[15:0]);
          ovf = (a < b) ? 16'hFFFF : 16'd0;
        end
        OP_MUL: begin
          r = a * b;
          poke_loc(la, r[15:0]);
          ovf = r[31:16];
        end
        OP_DIV: begin
          if (b == 0) begin
            poke_loc(la, 16'd0);
            ovf = '0;
          end else begin
            r = a / b;
            poke_loc(la, r[15:0]);
            r = (a << 16) / b;
            ovf = r[15:0];
          end
        end
        OP_MOD: begin
          r = (b == 0) ? 32'd0 : a % b;
          poke_loc(la, r[15:0]);
        end
        OP_SHL: begin
          wide = (b >= 48) ? 64'd0 : (64'(a) << b);
          poke_loc(la, wide[15:0]);
          ovf = wide[31:16];
        end
        OP_SHR: begin
          r = (b >= 16) ? 32'd0 : (a >> b);
          poke_loc(la, r[15:0]);
          r = (b >= 32) ? 32'd0 : ((a << 16) >> b);
          ovf = r[15:0];
        end
        OP_AND: poke_loc(la, 16'(a & b));
        OP_BOR: poke_loc(la, 16'(a | b));
        OP_XOR: poke_loc(la, 16'(a ^ b));
        OP_IFE: if (a != b) skip_next();
        OP_IFN: if (a == b) skip_next();
        OP_IFG: if (!(a > b)) skip_next();
        default: if ((a & b) == 0) skip_next();
      endcase
    endfunction

    // Called for every accepted command transfer.
    function void note_command(logic kind, logic [15:0] addr, logic [15:0] data);
      cpu_view_t v;
      if (kind == 1'b0) begin
        mem[addr] = data;
      end else begin
        execute();
        executed++;
      end
      v.pc = pc;
      v.sp = sp;
      v.ovf = ovf;
      foreach (gr[k]) v.gr[k] = gr[k];
      v.nxt = mem[pc];
      pending.push_back(v);
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Called for every result strobe.
    function void check_result(cpu_view_t act);
      cpu_view_t exp_v;
      string     reg_names[8];
      reg_names = '{"reg_a", "reg_b", "reg_c", "reg_x", "reg_y", "reg_z", "reg_i", "reg_j"};
      if (pending.size() == 0) begin
        $error("result strobe with no command outstanding");
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      checked++;
      cmp("pc", exp_v.pc, act.pc);
      cmp("sp", exp_v.sp, act.sp);
      cmp("overflow", exp_v.ovf, act.ovf);
      foreach (exp_v.gr[k]) cmp(reg_names[k], exp_v.gr[k], act.gr[k]);
      cmp("next_word", exp_v.nxt, act.nxt);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        kind_i;
  logic [15:0] address_i;
  logic [15:0] data_i;
  logic        valid_o;
  logic [15:0] pc_o;
  logic [15:0] sp_o;
  logic [15:0] overflow_o;
  logic [15:0] reg_a_o;
  logic [15:0] reg_b_o;
  logic [15:0] reg_c_o;
  logic [15:0] reg_x_o;
  logic [15:0] reg_y_o;
  logic [15:0] reg_z_o;
  logic [15:0] reg_i_o;
  logic [15:0] reg_j_o;
  logic [15:0] next_word_o;

  cpu_scoreboard sb;
  int unsigned   quiet_cycles;
  int unsigned   sender_idle_pct;

  word_cpu_instruction_step_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .address_i  (address_i),
    .data_i     (data_i),
    .valid_o    (valid_o),
    .pc_o       (pc_o),
    .sp_o       (sp_o),
    .overflow_o (overflow_o),
    .reg_a_o    (reg_a_o),
    .reg_b_o    (reg_b_o),
    .reg_c_o    (reg_c_o),
    .reg_x_o    (reg_x_o),
    .reg_y_o    (reg_y_o),
    .reg_z_o    (reg_z_o),
    .reg_i_o    (reg_i_o),
    .reg_j_o    (reg_j_o),
    .next_word_o(next_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All outputs of the core change only on the rising edge, so sampling at the
  // falling edge sees the values that the next rising edge will act on. A
  // command transfer and a result strobe are both recorded here.
  always @(negedge clk_i) begin
    cpu_view_t act;
    bit        active;
    if (rst_ni) begin
      active = 1'b0;
      if (start && !busy) begin
        sb.note_command(kind_i, address_i, data_i);
        active = 1'b1;
      end
      if (valid_o) begin
        act.pc = pc_o;
        act.sp = sp_o;
        act.ovf = overflow_o;
        act.gr = '{reg_a_o, reg_b_o, reg_c_o, reg_x_o, reg_y_o, reg_z_o, reg_i_o, reg_j_o};
        act.nxt = next_word_o;
        sb.check_result(act);
        active = 1'b1;
      end
      quiet_cycles <= active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Drives one command and returns at the rising edge at which it transfers.
  // Start is left high, so a following command that does not idle keeps it high.
  task automatic send_command(logic kind, logic [15:0] addr, logic [15:0] data);
    bit taken;
    while (($urandom % 100) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= kind;
    address_i <= addr;
    data_i <= data;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic load_word(logic [15:0] addr, logic [15:0] data);
    send_command(1'b0, addr, data);
  endtask

  // The address and data ports carry random junk during an execute command.
  task automatic step_cpu();
    send_command(1'b1, 16'($urandom), 16'($urandom));
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] encode(logic [3:0] op, logic [5:0] a, logic [5:0] b);
    return {b, a, op};
  endfunction

  // Operand codes lean toward registers and the stack so values get reused.
  function automatic logic [5:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 6'($urandom_range(0, 7));
    if (sel < 6) return 6'($urandom_range(6'h18, 6'h1F));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [15:0] random_instruction();
    logic [3:0] op;
    op = 4'($urandom_range(0, 15));
    if (op == OP_NONBASIC && $urandom_range(0, 9) < 7) return encode(op, NB_JSR, pick_operand());
    return encode(op, pick_operand(), pick_operand());
  endfunction

  task automatic run_directed();
    logic [15:0] prog[14];
    prog[0]  = encode(OP_SET, 6'h00, CODE_NW_LIT);      // A = 0xFFFF
    prog[1]  = 16'hFFFF;
    prog[2]  = encode(OP_ADD, 6'h00, 6'h21);            // carry out of A
    prog[3]  = encode(OP_SUB, 6'h01, 6'h21);            // borrow out of B
    prog[4]  = encode(OP_MUL, 6'h01, 6'h01);            // 0xFFFF squared
    prog[5]  = encode(OP_DIV, 6'h01, 6'h20);            // divide by zero
    prog[6]  = encode(OP_SET, 6'h03, 6'h3F);            // X = 31
    prog[7]  = encode(OP_SHL, 6'h03, CODE_O);           // shift with O as count
    prog[8]  = encode(OP_IFE, 6'h00, 6'h21);            // fails, skips three words
    prog[9]  = encode(OP_SET, CODE_NW_IND, CODE_NW_LIT);
    prog[10] = 16'h1234;
    prog[11] = 16'h5678;
    prog[12] = encode(OP_SET, 6'h3F, 6'h00);            // write to a literal
    prog[13] = encode(OP_NONBASIC, NB_JSR, 6'h20);      // call address 0
    load_word(16'hFFFF, 16'hFFFF);
    load_word(16'h0000, 16'h0000);
    foreach (prog[k]) load_word(16'(k), prog[k]);
    repeat (10) step_cpu();
  endtask

  // Most random work is short programs placed at the current PC and then run;
  // the rest is stray loads, stack loads and bare steps over whatever is there.
  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned sel;
    int unsigned n;
    logic [15:0] at;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        n = $urandom_range(1, 3);
        at = sb.pc;
        for (int unsigned k = 0; k < n; k++) begin
          load_word(at + 16'(k), (k == 0 || $urandom_range(0, 1)) ?
                    random_instruction() : 16'($urandom));
        end
        repeat ($urandom_range(1, 2)) step_cpu();
        done += n + 1;
      end else if (sel == 7) begin
        load_word(16'($urandom), 16'($urandom));
        done++;
      end else if (sel == 8) begin
        load_word(sb.sp + 16'($urandom_range(0, 3)), 16'($urandom));
        done++;
      end else begin
        step_cpu();
        done++;
      end
    end
  endtask

  initial begin
    int unsigned idle_plan[4];
    sb = new();
    quiet_cycles = 0;
    sender_idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = 1'b0;
    address_i = '0;
    data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    drain_results();

    // Phases: no gaps, a mostly idle sender, no gaps, a lightly idle sender.
    idle_plan = '{0, 62, 0, 24};
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      run_random(RANDOM_ITEMS / 4);
      if (p == 1) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk_i);

    $display("covered %0d results, %0d of them from executed instructions",
             sb.checked, sb.executed);
    $display("directed corner cases plus random programs under four sender gap profiles");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wcis_pkg.sv
hw/rtl/wcis_div.sv
hw/rtl/word_cpu_instruction_step_top.sv
tb/word_cpu_instruction_step_top_tb.sv
